// ===== rtl/core/pfrm_pkg.sv =====
package pfrm_pkg;

    localparam int TIME_BITS  = 48;
    localparam int RATE_BITS  = 24;
    localparam int CONST_BITS = 40;
    localparam int ALPHA_BITS = 9;
    localparam int TMO_BITS   = 32;
    localparam int IDX_BITS   = 2;
    localparam int PROD_BITS  = ALPHA_BITS + RATE_BITS;
    localparam int CNT_BITS   = $clog2(CONST_BITS + 1);

    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(256);
    localparam logic [PROD_BITS-1:0]  ROUND_HALF = PROD_BITS'(128);

    localparam logic [CONST_BITS-1:0] RATE_CONST_RST = CONST_BITS'(64'd7680000000);
    localparam logic [ALPHA_BITS-1:0] ALPHA_RST      = ALPHA_BITS'(26);
    localparam logic [TMO_BITS-1:0]   TIMEOUT_RST    = TMO_BITS'(1000000);

    typedef enum logic [IDX_BITS-1:0] {
        REG_RATE_CONST = 2'd0,
        REG_ALPHA      = 2'd1,
        REG_TIMEOUT    = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_PULSE = 1'b0,
        REQ_POLL  = 1'b1
    } req_kind_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_MUL_A = 6'b001000,
        ST_MUL_B = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/core/pfrm_cfg_if.sv =====
interface pfrm_cfg_if import pfrm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IDX_BITS-1:0]   index;
    logic [CONST_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pfrm_in_if.sv =====
interface pfrm_in_if import pfrm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [TIME_BITS-1:0] timestamp_us;

    modport source (output valid, output req_type, output timestamp_us, input ready);
    modport sink   (input valid, input req_type, input timestamp_us, output ready);
endinterface

// ===== rtl/core/pfrm_out_if.sv =====
interface pfrm_out_if import pfrm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [RATE_BITS-1:0] filtered_rate;
    logic [RATE_BITS-1:0] raw_rate;
    logic                 timed_out;

    modport source (output valid, output filtered_rate, output raw_rate, output timed_out,
                    input ready);
    modport sink   (input valid, input filtered_rate, input raw_rate, input timed_out,
                    output ready);
endinterface

// ===== rtl/core/pfrm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pfrm_div import pfrm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [CONST_BITS-1:0] dividend,
    input  logic [TIME_BITS-1:0]  divisor,
    output div_stat_t             stat,
    output logic [CONST_BITS-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]  rem_reg, rem_next;
    logic [TIME_BITS-1:0]  dvs_reg, dvs_next;
    logic [CONST_BITS-1:0] quo_reg, quo_next;
    logic [TIME_BITS:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[CONST_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(CONST_BITS);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = fits ? TIME_BITS'(trial - {1'b0, dvs_reg})
                                : trial[TIME_BITS-1:0];
                quo_next = {quo_reg[CONST_BITS-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);
    assign quotient  = quo_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(CONST_BITS))
        else $error("divider step count out of range");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && !start |=> !busy_reg)
        else $error("divider still busy after done");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == CNT_BITS'(CONST_BITS))
        else $error("divider start not taken");

endmodule

// ===== rtl/core/pulse_flow_rate_meter.sv =====
// Pulse-period flow meter. Each transfer on req is a sensor pulse or a poll with a
// microsecond timestamp; each one yields exactly one transfer on rsp holding the
// current raw and smoothed rates (ml/min, unsigned Q16.8). The block takes one
// request at a time. A pulse that updates the rate runs the 40-step serial divider
// for rate_constant / period, followed by two passes through one shared 9x24
// multiplier for the moving average. Polls, the first pulse and repeated
// timestamps skip the divider and multiplier. The user is to write registers on
// cfg only while the block is idle; the block itself does not enforce this. cfg is
// always ready and writes to unused indexes are dropped.
module pulse_flow_rate_meter import pfrm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    pfrm_cfg_if.sink    cfg,
    pfrm_in_if.sink     req,
    pfrm_out_if.source  rsp
);

    state_t                state_reg, state_next;

    logic [CONST_BITS-1:0] rate_const_reg;
    logic [ALPHA_BITS-1:0] alpha_reg;
    logic [TMO_BITS-1:0]   timeout_reg;

    logic [TIME_BITS-1:0]  last_pulse_time_reg;
    logic                  seen_pulse_reg;
    logic [RATE_BITS-1:0]  raw_rate_reg;
    logic [RATE_BITS-1:0]  filtered_rate_reg;

    logic                  kind_reg;
    logic [TIME_BITS-1:0]  ts_reg;
    logic [TIME_BITS-1:0]  delta_reg;
    logic                  expired_reg;
    logic [PROD_BITS-1:0]  acc_reg;

    logic                  out_valid_reg;
    logic [RATE_BITS-1:0]  out_filt_reg;
    logic [RATE_BITS-1:0]  out_raw_reg;
    logic                  out_tmo_reg;

    logic                  req_xfer;
    logic                  rsp_xfer;
    logic                  slot_free;
    logic                  div_start;
    div_stat_t             div_stat;
    logic [CONST_BITS-1:0] div_quo;
    logic [RATE_BITS-1:0]  quo_sat;
    logic [ALPHA_BITS-1:0] alpha_sat;
    logic [ALPHA_BITS-1:0] mul_a;
    logic [RATE_BITS-1:0]  mul_b;
    logic [PROD_BITS-1:0]  prod;
    logic [PROD_BITS-1:0]  ema_sum;

    assign req_xfer  = req.valid && req.ready;
    assign rsp_xfer  = rsp.valid && rsp.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_const_reg <= RATE_CONST_RST;
            alpha_reg      <= ALPHA_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_RATE_CONST: rate_const_reg <= cfg.data;
                REG_ALPHA:      alpha_reg      <= cfg.data[ALPHA_BITS-1:0];
                REG_TIMEOUT:    timeout_reg    <= cfg.data[TMO_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign div_start = (state_reg == ST_EVAL) && (kind_reg == REQ_PULSE)
                       && seen_pulse_reg && (delta_reg != '0);

    pfrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rate_const_reg),
        .divisor  (delta_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign quo_sat   = (div_quo[CONST_BITS-1:RATE_BITS] != '0) ? '1
                                                               : div_quo[RATE_BITS-1:0];
    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

    // shared multiplier: alpha*raw first, then (256-alpha)*filtered
    assign mul_a   = (state_reg == ST_MUL_A) ? alpha_sat : ALPHA_BITS'(ALPHA_ONE - alpha_sat);
    assign mul_b   = (state_reg == ST_MUL_A) ? raw_rate_reg : filtered_rate_reg;
    assign prod    = PROD_BITS'(mul_a * mul_b);
    assign ema_sum = acc_reg + prod + ROUND_HALF;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (req_xfer) state_next = ST_EVAL;
            ST_EVAL:  state_next = div_start ? ST_DIV : ST_DONE;
            ST_DIV:   if (div_stat.done) state_next = ST_MUL_A;
            ST_MUL_A: state_next = ST_MUL_B;
            ST_MUL_B: state_next = ST_DONE;
            ST_DONE:  if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            last_pulse_time_reg <= '0;
            seen_pulse_reg      <= 1'b0;
            raw_rate_reg        <= '0;
            filtered_rate_reg   <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // a new result may replace the one leaving in the same cycle
            if ((state_reg == ST_DONE) && slot_free)
                out_valid_reg <= 1'b1;
            else if (rsp_xfer)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_EVAL:
                begin
                    if (kind_reg == REQ_POLL)
                    begin
                        if (delta_reg > TIME_BITS'(timeout_reg))
                        begin
                            raw_rate_reg      <= '0;
                            filtered_rate_reg <= '0;
                        end
                    end
                    else
                    begin
                        if (!seen_pulse_reg)
                        begin
                            raw_rate_reg      <= '0;
                            filtered_rate_reg <= '0;
                            seen_pulse_reg    <= 1'b1;
                        end
                        last_pulse_time_reg <= ts_reg;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                        raw_rate_reg <= quo_sat;
                end
                ST_MUL_B:
                begin
                    filtered_rate_reg <= ema_sum[RATE_BITS+7:8];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            kind_reg  <= req.req_type;
            ts_reg    <= req.timestamp_us;
            delta_reg <= req.timestamp_us - last_pulse_time_reg;
        end
        if (state_reg == ST_EVAL)
            expired_reg <= (kind_reg == REQ_POLL) && (delta_reg > TIME_BITS'(timeout_reg));
        if (state_reg == ST_MUL_A)
            acc_reg <= prod;
        if ((state_reg == ST_DONE) && slot_free)
        begin
            out_filt_reg <= filtered_rate_reg;
            out_raw_reg  <= raw_rate_reg;
            out_tmo_reg  <= expired_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.filtered_rate = out_filt_reg;
    assign rsp.raw_rate      = out_raw_reg;
    assign rsp.timed_out     = out_tmo_reg;

    a_tmo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.timed_out |-> rsp.raw_rate == '0 && rsp.filtered_rate == '0)
        else $error("timed-out result carries nonzero rate");

    a_seen_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(seen_pulse_reg))
        else $error("seen_pulse cleared outside reset");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == ST_DIV)
        else $error("divider running outside divide step");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> !req.ready)
        else $error("request taken while busy");

endmodule
